[design/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg
// Types and constants shared by the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int TIME_W       = 16;
    localparam int SUM_W        = 32;
    localparam int JOB_SLOT_W   = 4;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_length;
    } t_in_item;

    typedef struct packed {
        logic [JOB_SLOT_W-1:0] job_slot;
        logic [TIME_W-1:0]     finish_time;
        logic [TIME_W-1:0]     turnaround;
        logic [TIME_W-1:0]     waiting;
        logic [SUM_W-1:0]      turnaround_sum;
        logic [SUM_W-1:0]      waiting_sum;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] total;
    } t_slot_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_TICK_SCAN,
        ST_UPDATE,
        ST_EMIT
    } t_state;

endpackage

[design/shortest_remaining_time_scheduler.sv]
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive shortest-remaining-time-first scheduler over a job table.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_item and raise start; the item is taken on a clock edge
//   where start is high and busy is low. action selects add or tick.
//   Add: scans valid bits from slot 0 for the lowest free slot, one slot per
//   cycle, and writes it there; a zero burst length or a full table drops it.
//   Tick: reads the table one slot per cycle through the single memory read
//   port and keeps the best candidate, then updates it.
//   Result: when a job finishes, o_result_valid is high for one cycle with
//   o_result, in the first cycle busy is low again. Results cannot be held
//   off; the strobe is the only notice.
//   Reset: the table is empty, time and running totals are zero; slot
//   contents need no clearing since valid bits gate every read.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler #(
    parameter int MAX_JOBS = srt_pkg::MAX_JOBS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  srt_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_result_valid,
    output srt_pkg::t_out_item o_result
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_JOBS - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_JOBS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_JOBS - 1);

    srt_pkg::t_state      r_state, n_state;
    srt_pkg::t_in_item    r_item;
    logic [MAX_JOBS-1:0]  r_valid;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_pv;
    logic                 r_plive;
    logic [IDX_W-1:0]     r_pslot;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_slot;
    srt_pkg::t_slot_entry r_best;
    logic [srt_pkg::TIME_W-1:0] r_time;
    logic [srt_pkg::TIME_W-1:0] r_fin;
    logic [srt_pkg::TIME_W-1:0] r_tat;
    logic [srt_pkg::SUM_W-1:0]  r_tat_sum;
    logic [srt_pkg::SUM_W-1:0]  r_wt_sum;
    srt_pkg::t_out_item   r_res;
    logic                 r_res_v;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    srt_pkg::t_slot_entry mem_wdata;
    logic                 mem_re;
    srt_pkg::t_slot_entry mem_rdata;

    logic [IDX_W-1:0]     idx;
    logic                 accept;
    logic                 slot_free;
    logic                 eligible;
    logic                 better;
    logic                 scan_last;
    logic [srt_pkg::TIME_W-1:0] rem_dec;
    logic [srt_pkg::TIME_W-1:0] wt;

    assign idx       = r_idx[IDX_W-1:0];
    assign accept    = start && (r_state == srt_pkg::ST_IDLE);
    assign slot_free = !r_valid[idx];
    assign eligible  = r_pv && r_plive && (mem_rdata.arrival <= r_time);
    assign better    = !r_found
                    || (mem_rdata.remaining < r_best.remaining)
                    || ((mem_rdata.remaining == r_best.remaining)
                        && (mem_rdata.arrival < r_best.arrival));
    assign scan_last = r_pv && (r_pslot == IDX_LAST);
    assign rem_dec   = r_best.remaining - srt_pkg::TIME_W'(1);
    assign wt        = r_tat - r_best.total;

    srt_slot_mem #(
        .DEPTH (MAX_JOBS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (idx),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = idx;
        mem_wdata = '{arrival:   r_item.arrival_time,
                      remaining: r_item.burst_length,
                      total:     r_item.burst_length};
        mem_re    = 1'b0;
        case (r_state)
            srt_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = (i_item.action == srt_pkg::ACT_TICK) ?
                              srt_pkg::ST_TICK_SCAN : srt_pkg::ST_ADD_SCAN;
                end
            end
            srt_pkg::ST_ADD_SCAN: begin
                if (r_item.burst_length == '0) begin
                    n_state = srt_pkg::ST_IDLE;
                end else if (slot_free) begin
                    mem_we  = 1'b1;
                    n_state = srt_pkg::ST_IDLE;
                end else if (r_idx == CNT_LAST) begin
                    n_state = srt_pkg::ST_IDLE;
                end
            end
            srt_pkg::ST_TICK_SCAN: begin
                mem_re = (r_idx < CNT_END);
                if (scan_last) begin
                    n_state = srt_pkg::ST_UPDATE;
                end
            end
            srt_pkg::ST_UPDATE: begin
                mem_waddr = r_best_slot;
                mem_wdata = '{arrival:   r_best.arrival,
                              remaining: rem_dec,
                              total:     r_best.total};
                mem_we    = r_found;
                if (r_found && (rem_dec == '0)) begin
                    n_state = srt_pkg::ST_EMIT;
                end else begin
                    n_state = srt_pkg::ST_IDLE;
                end
            end
            srt_pkg::ST_EMIT: begin
                n_state = srt_pkg::ST_IDLE;
            end
            default: begin
                n_state = srt_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_time    <= '0;
            r_tat_sum <= '0;
            r_wt_sum  <= '0;
            r_res_v   <= 1'b0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_res_v <= (r_state == srt_pkg::ST_EMIT);
            case (r_state)
                srt_pkg::ST_IDLE: begin
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                end
                srt_pkg::ST_ADD_SCAN: begin
                    if (mem_we) begin
                        r_valid[idx] <= 1'b1;
                    end
                end
                srt_pkg::ST_TICK_SCAN: begin
                    r_pv <= mem_re;
                    if (eligible && better) begin
                        r_found <= 1'b1;
                    end
                end
                srt_pkg::ST_UPDATE: begin
                    if (n_state == srt_pkg::ST_EMIT) begin
                        r_valid[r_best_slot] <= 1'b0;
                    end else begin
                        r_time <= r_time + srt_pkg::TIME_W'(1);
                    end
                end
                srt_pkg::ST_EMIT: begin
                    r_tat_sum <= r_tat_sum + srt_pkg::SUM_W'(r_tat);
                    r_wt_sum  <= r_wt_sum + srt_pkg::SUM_W'(wt);
                    r_time    <= r_time + srt_pkg::TIME_W'(1);
                end
                default: begin
                    r_pv <= 1'b0;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            srt_pkg::ST_IDLE: begin
                r_idx <= '0;
                if (accept) begin
                    r_item <= i_item;
                end
            end
            srt_pkg::ST_ADD_SCAN: begin
                r_idx <= r_idx + CNT_W'(1);
            end
            srt_pkg::ST_TICK_SCAN: begin
                if (mem_re) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                r_pslot <= idx;
                r_plive <= r_valid[idx];
                if (eligible && better) begin
                    r_best      <= mem_rdata;
                    r_best_slot <= r_pslot;
                end
            end
            srt_pkg::ST_UPDATE: begin
                r_fin <= r_time + srt_pkg::TIME_W'(1);
                r_tat <= r_time + srt_pkg::TIME_W'(1) - r_best.arrival;
            end
            srt_pkg::ST_EMIT: begin
                r_res.job_slot       <= srt_pkg::JOB_SLOT_W'(r_best_slot);
                r_res.finish_time    <= r_fin;
                r_res.turnaround     <= r_tat;
                r_res.waiting        <= wt;
                r_res.turnaround_sum <= r_tat_sum + srt_pkg::SUM_W'(r_tat);
                r_res.waiting_sum    <= r_wt_sum + srt_pkg::SUM_W'(wt);
            end
            default: begin
                r_idx <= '0;
            end
        endcase
    end

    assign busy           = (r_state != srt_pkg::ST_IDLE);
    assign o_result_valid = r_res_v;
    assign o_result       = r_res;

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_result_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && $past(r_state == srt_pkg::ST_EMIT)))
        else $error("result strobe without finished job");

    a_finish_clears_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srt_pkg::ST_EMIT) |-> !r_valid[r_best_slot])
        else $error("finished job still marked valid");

endmodule

[design/srt_slot_mem.sv]
// ----------------------------------------------------------------------------
// srt_slot_mem
// Job table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srt_slot_mem #(
    parameter int DEPTH = srt_pkg::MAX_JOBS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  srt_pkg::t_slot_entry          i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output srt_pkg::t_slot_entry          o_rdata
);

    srt_pkg::t_slot_entry r_mem [DEPTH];
    srt_pkg::t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
